// ===== rtl/b64e_pkg.sv =====
// b64e_pkg: shared types, constants and helper functions of the base64 line encoder.
// No dependencies; used by every other file of the block except b64e_if.
`timescale 1ns / 1ps

package b64e_pkg;

  // Kind of one output slot produced by the front end
  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_PAD = 2'd1;
  localparam logic [1:0] KIND_NL  = 2'd2;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] PAD_CHAR     = 8'h3D;

  localparam logic [5:0] GPL_RESET = 6'd19;

  // Most characters one input item can cause
  localparam int MAX_SLOTS = 6;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] six;
  } slot_t;

  // One queue entry: the characters of one input item, first in slot 0
  typedef struct packed {
    slot_t [MAX_SLOTS-1:0] slots;
    logic [2:0]            count;
  } cmd_t;

  function automatic slot_t make_slot(input logic [1:0] kind, input logic [5:0] six);
    slot_t s;
    s.kind = kind;
    s.six  = six;
    return s;
  endfunction

  // Standard base64 alphabet
  function automatic logic [7:0] sym_char(input logic [5:0] six);
    logic [7:0] c;
    if (six < 6'd26) begin
      c = 8'h41 + {2'b00, six};
    end else if (six < 6'd52) begin
      c = 8'h61 + {2'b00, six - 6'd26};
    end else if (six < 6'd62) begin
      c = 8'h30 + {2'b00, six - 6'd52};
    end else if (six == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== rtl/b64e_if.sv =====
// b64e_if: valid/ready stream interfaces for the byte input and the character output.
// Depends on nothing.
`timescale 1ns / 1ps

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_run;

  modport source (output valid, output out_char, output end_of_run, input ready);
  modport sink   (input valid, input out_char, input end_of_run, output ready);
endinterface

// ===== rtl/b64e_front.sv =====
// b64e_front: accepts input items, tracks group phase and line fill, and builds
// the list of output slots for each item. Depends on b64e_pkg and b64e_if.
`timescale 1ns / 1ps

module b64e_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [5:0]            cfg_data,
  b64e_in_if.sink               in_ch,
  input  logic                  q_full,
  output logic                  push,
  output b64e_pkg::cmd_t        push_cmd
);

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  logic [1:0] phase, phase_next;
  logic [3:0] lo, lo_next;
  logic [5:0] gil, gil_next;
  logic       any_done, any_done_next;
  logic [5:0] gpl;

  b64e_pkg::slot_t [b64e_pkg::MAX_SLOTS-1:0] base;
  logic [2:0] base_cnt;
  logic       nl;
  logic [7:0] b;
  logic       last;

  assign in_ch.ready = !q_full;
  assign push = in_ch.valid && in_ch.ready;
  assign b    = in_ch.data_byte;
  assign last = in_ch.final_byte;

  always_comb begin
    base          = '0;
    base_cnt      = 3'd1;
    nl            = 1'b0;
    phase_next    = phase;
    lo_next       = lo;
    gil_next      = gil;
    any_done_next = any_done;
    unique case (phase)
      PH_1: begin
        base[0] = b64e_pkg::make_slot(b64e_pkg::KIND_SYM, {lo[1:0], b[7:4]});
        base[1] = b64e_pkg::make_slot(b64e_pkg::KIND_SYM, {b[3:0], 2'b00});
        base[2] = b64e_pkg::make_slot(b64e_pkg::KIND_PAD, 6'd0);
        base[3] = b64e_pkg::make_slot(b64e_pkg::KIND_NL, 6'd0);
        base_cnt   = last ? 3'd4 : 3'd1;
        lo_next    = b[3:0];
        phase_next = PH_2;
      end
      PH_2: begin
        base[0] = b64e_pkg::make_slot(b64e_pkg::KIND_SYM, {lo, b[7:6]});
        base[1] = b64e_pkg::make_slot(b64e_pkg::KIND_SYM, b[5:0]);
        base[2] = b64e_pkg::make_slot(b64e_pkg::KIND_NL, 6'd0);
        base_cnt   = last ? 3'd3 : 3'd2;
        lo_next    = 4'd0;
        phase_next = PH_0;
      end
      default: begin
        // group start; an unused phase code behaves the same
        nl = any_done && (gil >= gpl);
        base[0] = b64e_pkg::make_slot(b64e_pkg::KIND_SYM, b[7:2]);
        base[1] = b64e_pkg::make_slot(b64e_pkg::KIND_SYM, {b[1:0], 4'b0000});
        base[2] = b64e_pkg::make_slot(b64e_pkg::KIND_PAD, 6'd0);
        base[3] = b64e_pkg::make_slot(b64e_pkg::KIND_PAD, 6'd0);
        base[4] = b64e_pkg::make_slot(b64e_pkg::KIND_NL, 6'd0);
        base_cnt      = last ? 3'd5 : 3'd1;
        gil_next      = (nl ? 6'd0 : gil) + 6'd1;
        any_done_next = 1'b1;
        lo_next       = {2'b00, b[1:0]};
        phase_next    = PH_1;
      end
    endcase
    if (last) begin
      phase_next    = PH_0;
      lo_next       = 4'd0;
      gil_next      = 6'd0;
      any_done_next = 1'b0;
    end
  end

  // leading newline shifts the list by one slot
  always_comb begin
    push_cmd.count = nl ? base_cnt + 3'd1 : base_cnt;
    for (int i = 0; i < b64e_pkg::MAX_SLOTS; i++) begin
      if (!nl) begin
        push_cmd.slots[i] = base[i];
      end else if (i == 0) begin
        push_cmd.slots[i] = b64e_pkg::make_slot(b64e_pkg::KIND_NL, 6'd0);
      end else begin
        push_cmd.slots[i] = base[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_0;
      lo       <= 4'd0;
      gil      <= 6'd0;
      any_done <= 1'b0;
      gpl      <= b64e_pkg::GPL_RESET;
    end else begin
      if (cfg_we) begin
        gpl <= cfg_data;
      end
      if (push) begin
        phase    <= phase_next;
        lo       <= lo_next;
        gil      <= gil_next;
        any_done <= any_done_next;
      end
    end
  end

`ifndef SYNTH
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_0) || (phase == PH_1) || (phase == PH_2))
    else $error("group phase reached unused code");
  a_lo_phase0: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_0) |-> (lo == 4'd0))
    else $error("leftover bits held at group start");
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (push && last) |=> (phase == PH_0 && gil == 6'd0 && !any_done))
    else $error("stream state not cleared after final item");
`endif

endmodule

// ===== rtl/b64e_queue.sv =====
// b64e_queue: small register FIFO of per-item slot lists between front and back.
// Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64e_pkg::cmd_t push_cmd,
  input  logic           pop,
  output b64e_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b64e_back.sv =====
// b64e_back: walks the slots of the queue head, maps them to ASCII and drives
// the output register. Depends on b64e_pkg and b64e_if.
`timescale 1ns / 1ps

module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  b64e_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  b64e_out_if.source     out_ch
);

  logic [2:0]      idx;
  logic            load;
  logic            at_end;
  b64e_pkg::slot_t cur;
  logic [7:0]      cur_char;
  logic            out_valid;

  assign load   = !empty && (!out_valid || out_ch.ready);
  assign at_end = (idx == head.count - 3'd1);
  assign pop    = load && at_end;
  assign cur    = head.slots[idx];
  assign out_ch.valid = out_valid;

  always_comb begin
    unique case (cur.kind)
      b64e_pkg::KIND_SYM: cur_char = b64e_pkg::sym_char(cur.six);
      b64e_pkg::KIND_PAD: cur_char = b64e_pkg::PAD_CHAR;
      default:            cur_char = b64e_pkg::NEWLINE_CHAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.out_char   <= cur_char;
      out_ch.end_of_run <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 3'd0 : idx + 3'd1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (idx < head.count))
    else $error("slot index beyond item length");
  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (head.count != 3'd0 && head.count <= 3'd6))
    else $error("queue head has illegal slot count");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    empty |-> (idx == 3'd0))
    else $error("slot index left mid-item with queue empty");
`endif

endmodule

// ===== rtl/base64_line_wrapped_encoder.sv =====
// base64_line_wrapped_encoder: top level of the base64 encoder with line wrapping.
// Depends on b64e_pkg, b64e_if, b64e_front, b64e_queue and b64e_back.
`timescale 1ns / 1ps

// Base64 encoder with MIME-style line wrapping. Raw bytes come in on in_ch, one
// item per byte with final_byte marking the end of a stream; ASCII characters go
// out on out_ch, one item per character, with end_of_run set on the last
// character caused by each input byte. Every three bytes give four alphabet
// characters; a newline is sent before a group that starts a new line once the
// line holds groups_per_line groups (cfg_data, reset 19, giving 76 columns; 0
// acts as 1). The final byte pads an incomplete group with '=' and closes with a
// newline, after which the next byte starts a fresh stream. Flow: the front end
// takes one byte per cycle while the slot queue (QUEUE_DEPTH entries) has room;
// the back end sends one character per cycle while out_ch is ready, so a byte
// gives one to six characters (four per three bytes, plus newlines) and the
// output port sets the sustained rate. Each byte is registered as an entry in
// the slot queue, and its characters then pass through the output register.
// Write cfg_data only while the block is idle.
module base64_line_wrapped_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  b64e_in_if.sink    in_ch,
  b64e_out_if.source out_ch
);

  // front to queue
  logic           push;
  b64e_pkg::cmd_t push_cmd;
  logic           q_full;

  // queue to back
  b64e_pkg::cmd_t head;
  logic           q_empty;
  logic           pop;

  // Front: group phase, line fill and the slot list for each byte
  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouples byte intake from character output
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: one character per cycle into the output register while out_ch is ready
  b64e_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for base64_line_wrapped_encoder.
// Depends on b64e_pkg, b64e_if and the encoder RTL; predicts every output character itself.
`timescale 1ns / 1ps

module tb;

  // One expected output item: the ASCII character and the end-of-run flag
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  // Position of the next input byte within its three-byte group
  typedef enum bit [1:0] {
    FIRST_BYTE  = 2'd0,
    SECOND_BYTE = 2'd1,
    THIRD_BYTE  = 2'd2
  } group_pos_t;

  // Encoder predictor plus the queue of characters still owed by the block.
  class char_scoreboard;
    char_item_t expected_chars[$];
    bit [5:0]   line_groups;
    group_pos_t pos;
    bit [3:0]   carry;
    bit [5:0]   groups_on_line;
    bit         line_started;
    int         errors;
    string      alphabet;

    function new();
      alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
                  "0123456789+/"};
      line_groups = b64e_pkg::GPL_RESET;
      errors = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      pos = FIRST_BYTE;
      carry = '0;
      groups_on_line = '0;
      line_started = 1'b0;
    endfunction

    function void set_line_groups(bit [5:0] v);
      line_groups = v;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function logic [7:0] symbol(bit [5:0] six);
      return alphabet[six];
    endfunction

    // Work out the characters caused by one accepted byte
    function void note_byte(logic [7:0] d, logic fin);
      logic [7:0] chars[$];
      char_item_t item;
      case (pos)
        SECOND_BYTE: begin
          chars.push_back(symbol({carry[1:0], d[7:4]}));
          carry = d[3:0];
          if (fin) begin
            chars.push_back(symbol({carry, 2'b00}));
            chars.push_back(b64e_pkg::PAD_CHAR);
          end else begin
            pos = THIRD_BYTE;
          end
        end
        THIRD_BYTE: begin
          chars.push_back(symbol({carry, d[7:6]}));
          chars.push_back(symbol(d[5:0]));
          carry = '0;
          pos = FIRST_BYTE;
        end
        default: begin
          // a new group: break the line first if it is full (0 acts as 1)
          if (line_started && groups_on_line >= line_groups) begin
            chars.push_back(b64e_pkg::NEWLINE_CHAR);
            groups_on_line = '0;
          end
          groups_on_line = groups_on_line + 6'd1;
          line_started = 1'b1;
          chars.push_back(symbol(d[7:2]));
          carry = {2'b00, d[1:0]};
          if (fin) begin
            chars.push_back(symbol({d[1:0], 4'b0000}));
            chars.push_back(b64e_pkg::PAD_CHAR);
            chars.push_back(b64e_pkg::PAD_CHAR);
          end else begin
            pos = SECOND_BYTE;
          end
        end
      endcase
      if (fin) begin
        chars.push_back(b64e_pkg::NEWLINE_CHAR);
        restart_stream();
      end
      foreach (chars[i]) begin
        item.ch = chars[i];
        item.last = (i == chars.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic eor);
      char_item_t exp_item;
      if (expected_chars.size() == 0) begin
        $error("out_char: no character expected, actual %h (end_of_run %b)", ch, eor);
        errors++;
        return;
      end
      exp_item = expected_chars.pop_front();
      if (ch !== exp_item.ch) begin
        $error("out_char mismatch: expected %h, actual %h", exp_item.ch, ch);
        errors++;
      end
      if (eor !== exp_item.last) begin
        $error("end_of_run mismatch: expected %b, actual %b", exp_item.last, eor);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [5:0] cfg_data;

  b64e_in_if  in_ch();
  b64e_out_if out_ch();

  base64_line_wrapped_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  char_scoreboard sb = new();

  // Flow-control knobs: steady for the driver and the output sink, the hold count for the sink
  bit steady;         // no idling on either side while set
  int out_hold_left;  // cycles the sink still holds ready low

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  // Output sink: checks every accepted character, then picks the next ready.
  // A pending hold-off wins over the random idling.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        sb.check_char(out_ch.out_char, out_ch.end_of_run);
      if (out_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        out_hold_left--;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and wait for the
  // handshake. Returns in the step of acceptance with valid still high.
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= d;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(d, fin);
  endtask

  // Random bytes; the last one closes the stream when close is set
  task automatic send_stream(input int len, input bit close);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
  endtask

  // Stop offering and wait until the block has sent everything it owes
  task automatic drain_output();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register write; only called with the block drained
  task automatic write_line_groups(input logic [5:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_line_groups(v);
  endtask

  initial begin
    int widths[6];
    int budget;
    int len;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    steady           = 1'b0;
    out_hold_left    = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- Directed part, at the reset line width ---
    // single byte: two pads
    send_byte(8'h00, 1'b1);
    // two bytes: one pad, all-ones data gives the '/' symbol
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // full group of '+' symbols, no pad
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    // top bit alone
    send_byte(8'h80, 1'b1);
    drain_output();

    // zero groups per line: a newline before every group but the first
    write_line_groups(6'd0);
    send_stream(7, 1'b1);
    drain_output();

    // widest line, then lowered mid-line: the next group must break the line
    write_line_groups(6'd63);
    send_stream(6, 1'b0);
    drain_output();
    write_line_groups(6'd1);
    send_stream(4, 1'b1);
    drain_output();

    // --- Random part: one phase per line width ---
    widths = '{19, 1, 63, 2, 0, 7};
    widths[4] = $urandom_range(0, 63);
    foreach (widths[p]) begin
      write_line_groups(6'(widths[p]));
      // first phase runs its long stream with no idling on either side
      steady = (p == 0);
      // long sink stall while bytes keep coming: the queue fills, input backs up
      if (p == 1)
        out_hold_left = 150;
      // a long stream that runs past the line break at the default width
      if (p == 0)
        send_stream($urandom_range(58, 62), 1'b1);
      budget = 4;
      while (budget > 0) begin
        len = $urandom_range(1, 9);
        if (len > budget)
          len = budget;
        budget -= len;
        // now and then the phase ends with a stream left open
        send_stream(len, (budget > 0) || ($urandom_range(0, 4) != 0));
      end
      drain_output();
    end
    steady = 1'b0;

    // close any open stream and let late or stray characters show up
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    drain_output();
    repeat (10) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_line_wrapped_encoder.sv
tb/sv/tb.sv
